>>> hdl/nhlt_pkg.sv
// shared types, codes and constants of the node heartbeat liveness table
package nhlt_pkg;

   localparam int MAX_NODES_DEFAULT = 8;
   localparam int ID_W              = 8;
   localparam int TIME_W            = 32;
   localparam int MAX_OUT           = 8;
   localparam int CNT_W             = $clog2(MAX_OUT + 1);

   localparam logic [TIME_W-1:0] HEARTBEAT_TIMEOUT_RESET  = 32'd60000;
   localparam logic [TIME_W-1:0] CONNECTION_TIMEOUT_RESET = 32'd300000;

   // configuration register indexes
   localparam logic REG_HEARTBEAT_TIMEOUT  = 1'b0;
   localparam logic REG_CONNECTION_TIMEOUT = 1'b1;

   typedef enum logic [1:0] {
      KIND_UPDATE = 2'd0,
      KIND_SWEEP  = 2'd1,
      KIND_QUERY  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      EV_CHANGE = 2'd0,
      EV_QUERY  = 2'd1,
      EV_FULL   = 2'd2
   } event_kind_type;

   // item walking down the row of cells
   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic [ID_W-1:0]   node_id;
      logic              connected;
      logic              online;
      logic [TIME_W-1:0] now_time;
      logic              found;
      logic [CNT_W-1:0]  cnt;
   } token_type;

   typedef struct packed {
      logic              valid;
      event_kind_type    ev;
      logic [ID_W-1:0]   node_id;
      logic              status;
   } result_type;

endpackage

>>> hdl/node_heartbeat_liveness_table.sv
// top level of the node heartbeat liveness table: a row of entry cells
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_ready | kind, node_id, connected, online, now_time
//   rsp     | out       | rsp_valid/rsp_ready | event_kind, node_id_res, status, last
//   csr     | in        | csr_valid/csr_ready | index, data (always ready)
//
// an item is registered, then visits one cell per cycle unless rsp back-pressure
// freezes the row, and ends in a finish step after the last cell of the row
// one item at a time; req_ready returns once the item has left the row
// rsp back-pressure freezes the whole row while a result cannot move on
// reset empties the table and restores both timeouts
module node_heartbeat_liveness_table #(
   parameter int MAX_NODES = nhlt_pkg::MAX_NODES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_kind,
   input  logic [nhlt_pkg::ID_W-1:0]   req_node_id,
   input  logic                        req_connected,
   input  logic                        req_online,
   input  logic [nhlt_pkg::TIME_W-1:0] req_now_time,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_event_kind,
   output logic [nhlt_pkg::ID_W-1:0]   rsp_node_id_res,
   output logic                        rsp_status,
   output logic                        rsp_last,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_index,
   input  logic [nhlt_pkg::TIME_W-1:0] csr_data
);
   import nhlt_pkg::*;

   logic [TIME_W-1:0] hb_timeout_ff;
   logic [TIME_W-1:0] conn_timeout_ff;

   token_type  tok0_ff;
   token_type  tok_chain [MAX_NODES+1];
   result_type cres [MAX_NODES];
   result_type fres;
   result_type res;
   token_type  tail;
   logic       adv;
   logic       busy;
   logic       accept;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hb_timeout_ff   <= HEARTBEAT_TIMEOUT_RESET;
         conn_timeout_ff <= CONNECTION_TIMEOUT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_HEARTBEAT_TIMEOUT:  hb_timeout_ff   <= csr_data;
            REG_CONNECTION_TIMEOUT: conn_timeout_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      busy = 1'b0;
      for (int i = 0; i <= MAX_NODES; i++) begin
         busy = busy | tok_chain[i].valid;
      end
   end

   assign req_ready = !busy;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tok0_ff.valid <= 1'b0;
      end else if (accept) begin
         tok0_ff.valid     <= 1'b1;
         tok0_ff.kind      <= kind_type'(req_kind);
         tok0_ff.node_id   <= req_node_id;
         tok0_ff.connected <= req_connected;
         tok0_ff.online    <= req_online;
         tok0_ff.now_time  <= req_now_time;
         tok0_ff.found     <= 1'b0;
         tok0_ff.cnt       <= '0;
      end else if (adv) begin
         tok0_ff.valid <= 1'b0;
      end
   end

   assign tok_chain[0] = tok0_ff;

   for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
      nhlt_cell u_cell (
         .clock              (clock),
         .reset              (reset),
         .adv                (adv),
         .tok_left           (tok_chain[g]),
         .tok_right          (tok_chain[g+1]),
         .res                (cres[g]),
         .heartbeat_timeout  (hb_timeout_ff),
         .connection_timeout (conn_timeout_ff)
      );
   end

   assign tail = tok_chain[MAX_NODES];

   // finish step: absent id on update or query
   always_comb begin
      fres         = '0;
      fres.node_id = tail.node_id;
      if (tail.valid && !tail.found) begin
         if (tail.kind == KIND_UPDATE) begin
            fres.valid = 1'b1;
            fres.ev    = EV_FULL;
         end else if (tail.kind == KIND_QUERY) begin
            fres.valid = 1'b1;
            fres.ev    = EV_QUERY;
         end
      end
   end

   // at most one stage holds the item, so at most one result is valid
   always_comb begin
      res = fres;
      for (int i = 0; i < MAX_NODES; i++) begin
         if (cres[i].valid) begin
            res = cres[i];
         end
      end
   end

   nhlt_out u_out (
      .clock           (clock),
      .reset           (reset),
      .res             (res),
      .done            (tail.valid),
      .adv             (adv),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_node_id_res (rsp_node_id_res),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

endmodule

>>> hdl/nhlt_cell.sv
// one table entry of the node row, acting on the item as it passes by
module nhlt_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  nhlt_pkg::token_type       tok_left,
   output nhlt_pkg::token_type       tok_right,
   output nhlt_pkg::result_type      res,
   input  logic [nhlt_pkg::TIME_W-1:0] heartbeat_timeout,
   input  logic [nhlt_pkg::TIME_W-1:0] connection_timeout
);
   import nhlt_pkg::*;

   logic              used_ff, used_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic              conn_ff, conn_in;
   logic              onl_ff, onl_in;
   logic [TIME_W-1:0] time_ff, time_in;
   token_type         tok_ff, tok_in;

   logic [TIME_W-1:0] elapsed;
   logic              hit;
   logic              old_c, old_o;
   logic              new_c, new_o;

   assign elapsed = tok_left.now_time - time_ff;
   assign hit     = used_ff && (id_ff == tok_left.node_id) && !tok_left.found;
   // an unused entry reads as both flags clear
   assign old_c   = used_ff & conn_ff;
   assign old_o   = used_ff & onl_ff;
   assign new_c   = conn_ff && !(elapsed > connection_timeout);
   assign new_o   = onl_ff && !(elapsed > heartbeat_timeout);

   always_comb begin
      used_in = used_ff;
      id_in   = id_ff;
      conn_in = conn_ff;
      onl_in  = onl_ff;
      time_in = time_ff;
      tok_in  = tok_left;
      res     = '0;
      if (tok_left.valid) begin
         unique case (tok_left.kind)
            KIND_UPDATE: begin
               // first free entry takes an absent id
               if (hit || (!used_ff && !tok_left.found)) begin
                  used_in      = 1'b1;
                  id_in        = tok_left.node_id;
                  conn_in      = tok_left.connected;
                  onl_in       = tok_left.online;
                  tok_in.found = 1'b1;
                  if (tok_left.online) begin
                     time_in = tok_left.now_time;
                  end else if (!used_ff) begin
                     time_in = '0;
                  end
                  if ((old_c != tok_left.connected) || (old_o != tok_left.online)) begin
                     res.valid   = 1'b1;
                     res.ev      = EV_CHANGE;
                     res.node_id = tok_left.node_id;
                     res.status  = tok_left.connected & tok_left.online;
                  end
               end
            end
            KIND_SWEEP: begin
               if (used_ff) begin
                  conn_in = new_c;
                  onl_in  = new_o;
                  if (((new_c & new_o) != (conn_ff & onl_ff)) &&
                      (tok_left.cnt < CNT_W'(MAX_OUT))) begin
                     res.valid   = 1'b1;
                     res.ev      = EV_CHANGE;
                     res.node_id = id_ff;
                     res.status  = new_c & new_o;
                     tok_in.cnt  = tok_left.cnt + 1'b1;
                  end
               end
            end
            KIND_QUERY: begin
               if (hit) begin
                  tok_in.found = 1'b1;
                  res.valid    = 1'b1;
                  res.ev       = EV_QUERY;
                  res.node_id  = tok_left.node_id;
                  res.status   = conn_ff & onl_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else if (adv) begin
         used_ff <= used_in;
         tok_ff  <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         id_ff   <= id_in;
         conn_ff <= conn_in;
         onl_ff  <= onl_in;
         time_ff <= time_in;
      end
   end

   assign tok_right = tok_ff;

endmodule

>>> hdl/nhlt_out.sv
// result hold stage and output register with last marking
module nhlt_out (
   input  logic                      clock,
   input  logic                      reset,
   input  nhlt_pkg::result_type      res,
   input  logic                      done,
   output logic                      adv,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_event_kind,
   output logic [nhlt_pkg::ID_W-1:0] rsp_node_id_res,
   output logic                      rsp_status,
   output logic                      rsp_last
);
   import nhlt_pkg::*;

   result_type hold_ff, hold_in;
   result_type out_ff, out_in;
   logic       last_ff, last_in;
   logic       out_free;
   logic       need_push;

   assign out_free  = !out_ff.valid || rsp_ready;
   // a result leaves the hold only once the next one (or the item end) is known
   assign need_push = done ? (res.valid || hold_ff.valid) : (res.valid && hold_ff.valid);
   assign adv       = !need_push || out_free;

   always_comb begin
      hold_in      = hold_ff;
      out_in       = out_ff;
      out_in.valid = out_ff.valid && !rsp_ready;
      last_in      = last_ff;
      if (adv) begin
         if (done) begin
            hold_in.valid = 1'b0;
            if (need_push) begin
               out_in       = res.valid ? res : hold_ff;
               out_in.valid = 1'b1;
               last_in      = 1'b1;
            end
         end else if (res.valid) begin
            if (hold_ff.valid) begin
               out_in  = hold_ff;
               last_in = 1'b0;
            end
            hold_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff.valid <= 1'b0;
         out_ff.valid  <= 1'b0;
      end else begin
         hold_ff <= hold_in;
         out_ff  <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
   end

   assign rsp_valid       = out_ff.valid;
   assign rsp_event_kind  = out_ff.ev;
   assign rsp_node_id_res = out_ff.node_id;
   assign rsp_status      = out_ff.status;
   assign rsp_last        = last_ff;

endmodule

>>> verif/node_liveness_checker.sv
// predictor and result comparison for the node heartbeat liveness table
module node_liveness_checker #(
   parameter int MAX_NODES = nhlt_pkg::MAX_NODES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [1:0]                  req_kind,
   input  logic [nhlt_pkg::ID_W-1:0]   req_node_id,
   input  logic                        req_connected,
   input  logic                        req_online,
   input  logic [nhlt_pkg::TIME_W-1:0] req_now_time,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [1:0]                  rsp_event_kind,
   input  logic [nhlt_pkg::ID_W-1:0]   rsp_node_id_res,
   input  logic                        rsp_status,
   input  logic                        rsp_last,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic                        csr_index,
   input  logic [nhlt_pkg::TIME_W-1:0] csr_data,
   output int                          failures,
   output int                          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import nhlt_pkg::*;

   typedef struct packed {
      event_kind_type  ev;
      logic [ID_W-1:0] node;
      logic            status;
      logic            last;
   } liveness_event_type;

   logic [ID_W-1:0]    node_tab  [MAX_NODES];
   logic               conn_tab  [MAX_NODES];
   logic               onl_tab   [MAX_NODES];
   logic [TIME_W-1:0]  beat_tab  [MAX_NODES];
   int                 node_total;
   logic [TIME_W-1:0]  beat_limit;
   logic [TIME_W-1:0]  link_limit;
   liveness_event_type expected_events[$];

   function automatic int lookup_node(logic [ID_W-1:0] id);
      int hit;
      hit = -1;
      for (int i = 0; i < node_total; i++)
         if (hit < 0 && node_tab[i] == id) hit = i;
      return hit;
   endfunction

   function automatic void predict_liveness(logic [1:0] kind, logic [ID_W-1:0] id,
                                            logic conn, logic onl,
                                            logic [TIME_W-1:0] now);
      liveness_event_type batch[$];
      liveness_event_type ev;
      int                 slot;
      logic               was;
      logic               st;
      logic [TIME_W-1:0]  elapsed;
      ev = '0;
      case (kind)
         KIND_UPDATE: begin
            slot = lookup_node(id);
            if (slot < 0 && node_total >= MAX_NODES) begin
               ev.ev = EV_FULL;
               ev.node = id;
               ev.status = 1'b0;
               batch.push_back(ev);
            end else begin
               // a new node starts with both flags clear and a zero stamp
               if (slot < 0) begin
                  slot = node_total;
                  node_tab[slot] = id;
                  conn_tab[slot] = 1'b0;
                  onl_tab[slot] = 1'b0;
                  beat_tab[slot] = '0;
                  node_total++;
               end
               if (conn_tab[slot] != conn || onl_tab[slot] != onl) begin
                  ev.ev = EV_CHANGE;
                  ev.node = id;
                  ev.status = conn & onl;
                  batch.push_back(ev);
               end
               conn_tab[slot] = conn;
               onl_tab[slot] = onl;
               if (onl) beat_tab[slot] = now;
            end
         end
         KIND_SWEEP: begin
            for (int i = 0; i < node_total; i++) begin
               was = conn_tab[i] & onl_tab[i];
               elapsed = now - beat_tab[i];
               if (onl_tab[i] && elapsed > beat_limit) onl_tab[i] = 1'b0;
               if (conn_tab[i] && elapsed > link_limit) conn_tab[i] = 1'b0;
               st = conn_tab[i] & onl_tab[i];
               if (st != was && batch.size() < MAX_OUT) begin
                  ev.ev = EV_CHANGE;
                  ev.node = node_tab[i];
                  ev.status = st;
                  batch.push_back(ev);
               end
            end
         end
         KIND_QUERY: begin
            slot = lookup_node(id);
            ev.ev = EV_QUERY;
            ev.node = id;
            ev.status = (slot >= 0) ? (conn_tab[slot] & onl_tab[slot]) : 1'b0;
            batch.push_back(ev);
         end
         default: ;
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) expected_events.push_back(batch[i]);
   endfunction

   always @(posedge clock) begin
      liveness_event_type want;
      if (reset) begin
         node_total = 0;
         beat_limit = HEARTBEAT_TIMEOUT_RESET;
         link_limit = CONNECTION_TIMEOUT_RESET;
         expected_events.delete();
         failures = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("%0t: unexpected result kind %0d node %0d status %0b last %0b",
                           $realtime, rsp_event_kind, rsp_node_id_res, rsp_status, rsp_last);
            end else begin
               want = expected_events.pop_front();
               if (rsp_event_kind !== want.ev || rsp_node_id_res !== want.node ||
                   rsp_status !== want.status || rsp_last !== want.last) begin
                  failures++;
                  if (failures <= 10)
                     $display("%0t: expected %0d %0d %0b %0b, got %0d %0d %0b %0b",
                              $realtime, want.ev, want.node, want.status, want.last,
                              rsp_event_kind, rsp_node_id_res, rsp_status, rsp_last);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_HEARTBEAT_TIMEOUT) beat_limit = csr_data;
            else link_limit = csr_data;
         end
         if (req_valid && req_ready)
            predict_liveness(req_kind, req_node_id, req_connected, req_online, req_now_time);
      end
      outstanding <= expected_events.size();
   end

endmodule

>>> verif/node_heartbeat_liveness_table_test.sv
// stimulus and verdict for the node heartbeat liveness table
module node_heartbeat_liveness_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   import nhlt_pkg::*;

   localparam int         MAX_NODES     = 8;
   localparam int         SETTLE_CYCLES = MAX_NODES + 10;
   localparam int         PHASE_ITEMS   = 65;
   localparam logic [1:0] KIND_UNUSED   = 2'd3;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_kind = '0;
   logic [ID_W-1:0]     req_node_id = '0;
   logic                req_connected = 1'b0;
   logic                req_online = 1'b0;
   logic [TIME_W-1:0]   req_now_time = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [1:0]          rsp_event_kind;
   logic [ID_W-1:0]     rsp_node_id_res;
   logic                rsp_status;
   logic                rsp_last;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_index = 1'b0;
   logic [TIME_W-1:0]   csr_data = '0;
   int                  failures;
   int                  outstanding;

   logic [TIME_W-1:0]   cur_time;
   logic [TIME_W-1:0]   last_stamp;
   logic [TIME_W-1:0]   beat_to;
   logic [TIME_W-1:0]   link_to;
   bit                  calm = 1'b0;
   logic [ID_W-1:0]     roster[8] = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h0F, 8'hF0, 8'h33, 8'hCC};

   always #5 clock = ~clock;

   node_heartbeat_liveness_table #(.MAX_NODES(MAX_NODES)) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_node_id     (req_node_id),
      .req_connected   (req_connected),
      .req_online      (req_online),
      .req_now_time    (req_now_time),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_node_id_res (rsp_node_id_res),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   node_liveness_checker #(.MAX_NODES(MAX_NODES)) i_liveness_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_node_id     (req_node_id),
      .req_connected   (req_connected),
      .req_online      (req_online),
      .req_now_time    (req_now_time),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_node_id_res (rsp_node_id_res),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .failures        (failures),
      .outstanding     (outstanding)
   );

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // one transfer on the request channel, then a random gap
   task automatic issue(logic [1:0] kind, logic [ID_W-1:0] id, logic conn, logic onl,
                        logic [TIME_W-1:0] now);
      int gap;
      req_valid <= 1'b1;
      req_kind <= kind;
      req_node_id <= id;
      req_connected <= conn;
      req_online <= onl;
      req_now_time <= now;
      do @(posedge clock); while (!req_ready);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drain all pending results, then let a possibly silent item finish
   task automatic quiesce();
      int spins;
      req_valid <= 1'b0;
      spins = 0;
      @(posedge clock);
      while (outstanding != 0 && spins < 20000) begin
         @(posedge clock);
         spins++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_timeouts(logic [TIME_W-1:0] hb, logic [TIME_W-1:0] cn);
      csr_valid <= 1'b1;
      csr_index <= REG_HEARTBEAT_TIMEOUT;
      csr_data <= hb;
      do @(posedge clock); while (!csr_ready);
      csr_index <= REG_CONNECTION_TIMEOUT;
      csr_data <= cn;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      beat_to = hb;
      link_to = cn;
   endtask

   task automatic random_item(output bit counted);
      int                r;
      logic [ID_W-1:0]   id;
      logic              conn;
      logic              onl;
      logic [TIME_W-1:0] now;
      r = $urandom_range(0, 99);
      id = ($urandom_range(0, 99) < 85) ? roster[$urandom_range(0, 7)]
                                        : ID_W'($urandom_range(0, 255));
      conn = 1'($urandom_range(0, 1));
      onl = 1'($urandom_range(0, 1));
      counted = 1'b1;
      if (r < 55) begin
         now = cur_time + $urandom_range(0, 20);
         cur_time = now;
         if (onl) last_stamp = now;
         issue(KIND_UPDATE, id, conn, onl, now);
      end else if (r < 75) begin
         // aim sweeps around both timeout edges, plus wide jumps that wrap
         case ($urandom_range(0, 5))
            0: now = cur_time + $urandom_range(0, 50);
            1: now = last_stamp + beat_to + $urandom_range(0, 2) - 1;
            2: now = last_stamp + link_to + $urandom_range(0, 2) - 1;
            3: now = $urandom();
            4: now = cur_time + $urandom_range(0, beat_to);
            default: now = cur_time + $urandom_range(beat_to, link_to);
         endcase
         cur_time = now;
         issue(KIND_SWEEP, id, conn, onl, now);
      end else if (r < 95) begin
         issue(KIND_QUERY, id, conn, onl, $urandom());
      end else begin
         counted = 1'b0;
         issue(KIND_UNUSED, id, conn, onl, $urandom());
      end
   endtask

   initial begin
      int  hold;
      int  stall;
      @(posedge clock);
      forever begin
         hold = $urandom_range(1, 12);
         stall = calm ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 3));
         rsp_ready <= 1'b1;
         repeat (hold) @(posedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin
      int done;
      bit counted;
      cur_time = '0;
      last_stamp = '0;
      beat_to = HEARTBEAT_TIMEOUT_RESET;
      link_to = CONNECTION_TIMEOUT_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      issue(KIND_QUERY, 8'h00, 1'b0, 1'b0, 32'd0);
      issue(KIND_UPDATE, 8'h00, 1'b0, 1'b0, 32'd0);
      issue(KIND_UPDATE, 8'hFF, 1'b1, 1'b1, 32'd100);
      issue(KIND_UPDATE, 8'h5A, 1'b1, 1'b0, 32'd200);
      issue(KIND_UPDATE, 8'hA5, 1'b0, 1'b1, 32'd300);
      issue(KIND_UPDATE, 8'h0F, 1'b1, 1'b1, 32'hFFFF_FFFF);
      issue(KIND_UPDATE, 8'hF0, 1'b1, 1'b1, 32'd400);
      issue(KIND_UPDATE, 8'h33, 1'b0, 1'b0, 32'd500);
      issue(KIND_UPDATE, 8'hCC, 1'b1, 1'b1, 32'd600);
      // table is full now
      issue(KIND_UPDATE, 8'h77, 1'b1, 1'b1, 32'd650);
      issue(KIND_UPDATE, 8'hFF, 1'b1, 1'b1, 32'd700);
      issue(KIND_QUERY, 8'hFF, 1'b0, 1'b0, 32'd700);
      issue(KIND_QUERY, 8'h77, 1'b1, 1'b1, 32'd700);
      issue(KIND_UNUSED, 8'h5A, 1'b1, 1'b1, 32'd700);
      issue(KIND_SWEEP, 8'h00, 1'b0, 1'b0, 32'd700);
      issue(KIND_SWEEP, 8'h00, 1'b0, 1'b0, 32'd60700);
      issue(KIND_SWEEP, 8'h00, 1'b0, 1'b0, 32'd60701);
      issue(KIND_SWEEP, 8'h00, 1'b0, 1'b0, 32'd300401);
      issue(KIND_UPDATE, 8'h0F, 1'b1, 1'b1, 32'hFFFF_FFF0);
      issue(KIND_SWEEP, 8'h00, 1'b0, 1'b0, 32'h0000_0010);
      issue(KIND_QUERY, 8'h0F, 1'b0, 1'b0, 32'h0000_0010);
      cur_time = 32'h0000_0010;
      last_stamp = 32'hFFFF_FFF0;

      for (int phase = 0; phase < 6; phase++) begin
         if (phase > 0) begin
            quiesce();
            case (phase)
               1: set_timeouts(32'd1, 32'd1);
               2: set_timeouts(32'hFFFF_FFFF, 32'hFFFF_FFFF);
               3: set_timeouts($urandom_range(1, 2000), $urandom_range(1, 8000));
               4: set_timeouts($urandom_range(1, 32'hFFFF_FFFF),
                               $urandom_range(1, 32'hFFFF_FFFF));
               default: set_timeouts($urandom_range(5000, 50000), $urandom_range(1, 4000));
            endcase
         end
         calm = (phase == 1) || ($urandom_range(0, 3) == 0);
         done = 0;
         while (done < PHASE_ITEMS) begin
            random_item(counted);
            if (counted) done++;
         end
      end

      calm = 1'b0;
      quiesce();
      if (failures == 0 && outstanding == 0)
         $display("node_heartbeat_liveness_table verification clean");
      else
         $display("node_heartbeat_liveness_table verification failed");
      $finish;
   end

   initial begin
      #(10_000_000);
      $display("node_heartbeat_liveness_table verification failed");
      $finish;
   end

endmodule
